[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; all checks are disabled while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BDP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bdp assertion failed");

// Implication checked in the next cycle.
`define BDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bdp assertion failed");

`endif

[hw/rtl/bdp_pkg.sv]
package bdp_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int CNT_W       = 4;

    localparam logic [CNT_W-1:0] CNT_MAX      = 4'hF;
    localparam logic [CNT_W-1:0] POLLS_RESET  = 4'd3;

    localparam logic [22:0] THR_LOW    = 23'd4194304;
    localparam logic [22:0] THR_HIGH   = 23'd1677721;
    localparam logic [4:0]  GAIN_LOW   = 5'd4;
    localparam logic [4:0]  GAIN_HIGH  = 5'd12;
    localparam logic [31:0] RATE_SLOW  = 32'd89478;
    localparam logic [31:0] RATE_FAST  = 32'd357914;
    localparam logic [6:0]  DEPTH_SLOW = 7'd80;
    localparam logic [6:0]  DEPTH_FAST = 7'd100;
    localparam logic [5:0]  RGB_SW0    = 6'h02;
    localparam logic [5:0]  RGB_SW1    = 6'h10;

    // Wah floor preset codes
    localparam logic [1:0] WAH_A      = 2'd0;
    localparam logic [1:0] WAH_B      = 2'd1;
    localparam logic [1:0] WAH_C      = 2'd2;
    localparam logic [1:0] WAH_UNUSED = 2'd3;

    localparam logic [3:0] FLOOR_A = 4'd6;
    localparam logic [3:0] FLOOR_B = 4'd4;
    localparam logic [3:0] FLOOR_C = 4'd0;

    typedef struct packed {
        logic [1:0] switches;
        logic [2:0] buttons;
    } poll_t;

    typedef struct packed {
        logic        dist_enable;
        logic        wobble_enable;
        logic        enables_changed;
        logic [2:0]  presets_fired;
        logic [22:0] clip_threshold;
        logic [4:0]  drive_gain;
        logic [31:0] lfo_increment;
        logic [6:0]  sweep_depth;
        logic [3:0]  floor_index;
        logic [1:0]  led_bits;
        logic [5:0]  rgb_bits;
    } result_t;

    function automatic logic [3:0] floor_of(input logic [1:0] choice);
        logic [3:0] f;
        case (choice)
            WAH_A:   f = FLOOR_A;
            WAH_B:   f = FLOOR_B;
            WAH_C:   f = FLOOR_C;
            default: f = FLOOR_C;
        endcase
        return f;
    endfunction

endpackage

[hw/rtl/bdp_debounce.sv]
`include "assert_macros.svh"

module bdp_debounce (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       pressed,
    input  logic [bdp_pkg::CNT_W-1:0]  polls,
    output logic                       fire
);

    logic [bdp_pkg::CNT_W-1:0] count_reg;
    logic [bdp_pkg::CNT_W-1:0] count_next;
    logic                      fired_reg;
    logic                      fired_next;
    logic [bdp_pkg::CNT_W-1:0] count_inc;

    // Saturate at the top of the counter. A zero setting behaves as one.
    assign count_inc = (count_reg == bdp_pkg::CNT_MAX) ? count_reg : count_reg + 1'b1;
    assign fire      = pressed && !fired_reg && (count_inc >= polls);

    always_comb
    begin
        count_next = count_reg;
        fired_next = fired_reg;
        if (advance)
        begin
            if (!pressed)
            begin
                count_next = '0;
                fired_next = 1'b0;
            end
            else if (!fired_reg)
            begin
                count_next = count_inc;
                fired_next = fire;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fired_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fired_reg <= fired_next;
        end
    end

    `BDP_ASSERT_NOW(a_fired_has_count, clk, rst_n, fired_reg, count_reg != '0)
    `BDP_ASSERT_NEXT(a_fire_latches, clk, rst_n, advance && fire, fired_reg)
    `BDP_ASSERT_NEXT(a_release_clears, clk, rst_n, advance && !pressed,
                     count_reg == '0 && !fired_reg)

endmodule

[hw/rtl/bdp_presets.sv]
module bdp_presets (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic [1:0]                        switches,
    input  logic [bdp_pkg::NUM_BUTTONS-1:0]   fired,
    output bdp_pkg::result_t                  result
);

    logic       dist_high_reg;
    logic       dist_high_next;
    logic       wobble_fast_reg;
    logic       wobble_fast_next;
    logic [1:0] wah_choice_reg;
    logic [1:0] wah_choice_next;
    logic [1:0] last_switches_reg;
    logic       switches_seen_reg;

    always_comb
    begin
        dist_high_next   = dist_high_reg ^ fired[0];
        wobble_fast_next = wobble_fast_reg ^ fired[1];
        wah_choice_next  = wah_choice_reg;
        if (fired[2])
        begin
            if (wah_choice_reg == bdp_pkg::WAH_C || wah_choice_reg == bdp_pkg::WAH_UNUSED)
                wah_choice_next = bdp_pkg::WAH_A;
            else
                wah_choice_next = wah_choice_reg + 2'd1;
        end
    end

    // Parameters reflect the presets as they stand after this poll.
    always_comb
    begin
        result.dist_enable     = switches[0];
        result.wobble_enable   = switches[1];
        result.enables_changed = !switches_seen_reg || (switches != last_switches_reg);
        result.presets_fired   = fired;
        result.clip_threshold  = dist_high_next ? bdp_pkg::THR_HIGH : bdp_pkg::THR_LOW;
        result.drive_gain      = dist_high_next ? bdp_pkg::GAIN_HIGH : bdp_pkg::GAIN_LOW;
        result.lfo_increment   = wobble_fast_next ? bdp_pkg::RATE_FAST : bdp_pkg::RATE_SLOW;
        result.sweep_depth     = wobble_fast_next ? bdp_pkg::DEPTH_FAST : bdp_pkg::DEPTH_SLOW;
        result.floor_index     = bdp_pkg::floor_of(wah_choice_next);
        result.led_bits        = {wobble_fast_next, dist_high_next};
        result.rgb_bits        = (switches[0] ? bdp_pkg::RGB_SW0 : 6'd0)
                               | (switches[1] ? bdp_pkg::RGB_SW1 : 6'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_high_reg     <= 1'b0;
            wobble_fast_reg   <= 1'b0;
            wah_choice_reg    <= bdp_pkg::WAH_A;
            last_switches_reg <= 2'd0;
            switches_seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            dist_high_reg     <= dist_high_next;
            wobble_fast_reg   <= wobble_fast_next;
            wah_choice_reg    <= wah_choice_next;
            last_switches_reg <= switches;
            switches_seen_reg <= 1'b1;
        end
    end

endmodule

[hw/rtl/button_debounce_preset_panel_top.sv]
// Switch and button control panel for an audio effect block.
// poll channel (poll_valid/poll_ready/poll): one transaction is one poll of
// two switches and three buttons. result channel (result_valid/result_ready/
// result): exactly one transaction per poll, in poll order, carrying the
// effect enables, the fired-preset mask, the preset parameters and LED bits.
// cfg_we/cfg_wdata write the debounce length (polls a button must be held
// before it fires); write it only while no poll is in flight.
// An accepted poll waits in the poll register and moves on into the result
// register when that slot is free (two register stages: poll register,
// result register). Throughput: one poll per cycle while results are taken,
// set by the single pass of the debouncers and preset logic between them.
// A stalled result holds the result register; the poll register fills behind
// it, and poll_ready drops only when both hold a transaction.
// Reset clears all presets to low/slow/A, the debouncers, the first-poll mark
// and both valid flags, and loads a debounce length of 3.
module button_debounce_preset_panel_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  poll_valid,
    output logic                  poll_ready,
    input  bdp_pkg::poll_t        poll,
    output logic                  result_valid,
    input  logic                  result_ready,
    output bdp_pkg::result_t      result,
    input  logic                  cfg_we,
    input  logic [3:0]            cfg_wdata
);

    logic                              s1_valid_reg;
    bdp_pkg::poll_t                    s1_poll_reg;
    logic                              result_valid_reg;
    bdp_pkg::result_t                  result_reg;
    logic [bdp_pkg::CNT_W-1:0]         polls_reg;
    logic                              advance;
    logic [bdp_pkg::NUM_BUTTONS-1:0]   fired;
    bdp_pkg::result_t                  result_next;

    // Move the held poll into the result register when that slot frees up.
    assign advance    = s1_valid_reg && (!result_valid_reg || result_ready);
    assign poll_ready = !s1_valid_reg || advance;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    genvar gi;
    generate
        for (gi = 0; gi < bdp_pkg::NUM_BUTTONS; gi++)
        begin : g_btn
            bdp_debounce u_debounce (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .pressed (s1_poll_reg.buttons[gi]),
                .polls   (polls_reg),
                .fire    (fired[gi])
            );
        end
    endgenerate

    bdp_presets u_presets (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .switches (s1_poll_reg.switches),
        .fired    (fired),
        .result   (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            polls_reg        <= bdp_pkg::POLLS_RESET;
        end
        else
        begin
            if (cfg_we)
                polls_reg <= cfg_wdata;
            if (poll_ready)
                s1_valid_reg <= poll_valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && poll_ready)
            s1_poll_reg <= poll;
        if (advance)
            result_reg <= result_next;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_POLLS_PER_SETTING = 72;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             poll_valid = 1'b0;
    logic             poll_ready;
    bdp_pkg::poll_t   poll = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    bdp_pkg::result_t result;
    logic             cfg_we = 1'b0;
    logic [3:0]       cfg_wdata = 4'd0;

    button_debounce_preset_panel_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Panel state as the block should hold it
    logic [3:0] debounce_len = bdp_pkg::POLLS_RESET;
    logic       preset_dist_high = 1'b0;
    logic       preset_wobble_fast = 1'b0;
    logic [1:0] preset_wah = bdp_pkg::WAH_A;
    logic [1:0] prev_switches = 2'b00;
    logic       switches_valid = 1'b0;
    logic [3:0] hold_count [bdp_pkg::NUM_BUTTONS];
    logic       hold_fired [bdp_pkg::NUM_BUTTONS];

    bdp_pkg::poll_t   pending_polls [$];
    bdp_pkg::result_t expected_results [$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    int  polls_queued = 0;
    bit  poll_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_idx = 4'd0;
    logic [1:0]  cur_switches = 2'b00;

    initial
    begin
        for (int i = 0; i < bdp_pkg::NUM_BUTTONS; i++)
        begin
            hold_count[i] = 4'd0;
            hold_fired[i] = 1'b0;
        end
    end

    function automatic bdp_pkg::result_t predict_panel(input bdp_pkg::poll_t p);
        bdp_pkg::result_t r;
        logic [2:0]       fire;
        fire = 3'b000;
        r.enables_changed = !switches_valid || (p.switches != prev_switches);
        prev_switches = p.switches;
        switches_valid = 1'b1;
        for (int i = 0; i < bdp_pkg::NUM_BUTTONS; i++)
        begin
            if (!p.buttons[i])
            begin
                hold_count[i] = 4'd0;
                hold_fired[i] = 1'b0;
            end
            else if (!hold_fired[i])
            begin
                // saturate the hold counter at its ceiling
                if (hold_count[i] != bdp_pkg::CNT_MAX)
                    hold_count[i] = hold_count[i] + 4'd1;
                if (hold_count[i] >= debounce_len)
                begin
                    hold_fired[i] = 1'b1;
                    fire[i] = 1'b1;
                end
            end
        end
        if (fire[0])
            preset_dist_high = !preset_dist_high;
        if (fire[1])
            preset_wobble_fast = !preset_wobble_fast;
        if (fire[2])
            preset_wah = (preset_wah >= bdp_pkg::WAH_C) ? bdp_pkg::WAH_A : preset_wah + 2'd1;

        r.dist_enable    = p.switches[0];
        r.wobble_enable  = p.switches[1];
        r.presets_fired  = fire;
        r.clip_threshold = preset_dist_high ? bdp_pkg::THR_HIGH : bdp_pkg::THR_LOW;
        r.drive_gain     = preset_dist_high ? bdp_pkg::GAIN_HIGH : bdp_pkg::GAIN_LOW;
        r.lfo_increment  = preset_wobble_fast ? bdp_pkg::RATE_FAST : bdp_pkg::RATE_SLOW;
        r.sweep_depth    = preset_wobble_fast ? bdp_pkg::DEPTH_FAST : bdp_pkg::DEPTH_SLOW;
        case (preset_wah)
            bdp_pkg::WAH_A: r.floor_index = bdp_pkg::FLOOR_A;
            bdp_pkg::WAH_B: r.floor_index = bdp_pkg::FLOOR_B;
            default:        r.floor_index = bdp_pkg::FLOOR_C;
        endcase
        r.led_bits = {preset_wobble_fast, preset_dist_high};
        r.rgb_bits = (p.switches[0] ? bdp_pkg::RGB_SW0 : 6'h00)
                   | (p.switches[1] ? bdp_pkg::RGB_SW1 : 6'h00);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_poll(input logic [1:0] sw, input logic [2:0] btn);
        bdp_pkg::poll_t p;
        p.switches = sw;
        p.buttons = btn;
        pending_polls.push_back(p);
        polls_queued++;
    endtask

    // Mostly clean press-and-hold runs around the debounce length, some bounce noise
    task automatic queue_button_runs(input int n_polls);
        int target;
        int hold_len;
        int lim;
        logic [2:0] mask;
        target = polls_queued + n_polls;
        while (polls_queued < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                mask = 3'($urandom_range(1, 7));
                lim = (debounce_len == 4'd0) ? 1 : int'(debounce_len);
                hold_len = $urandom_range(1, lim + 4);
                repeat (hold_len)
                begin
                    if ($urandom_range(0, 3) == 0)
                        cur_switches = 2'($urandom_range(0, 3));
                    push_poll(cur_switches, mask);
                end
                repeat ($urandom_range(1, 2))
                    push_poll(cur_switches, 3'b000);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_poll(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_polls.size() != 0 || poll_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_debounce(input logic [3:0] polls);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= polls;
        debounce_len = polls;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Poll driver: bursts with random gaps
    always @(negedge clk)
    begin : drive_polls
        logic           nxt_valid;
        bdp_pkg::poll_t nxt_poll;
        nxt_valid = poll_valid;
        nxt_poll = poll;
        if (poll_taken)
            nxt_valid = 1'b0;
        poll_taken = 1'b0;
        if (rst_n && !nxt_valid)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pending_polls.size() != 0)
            begin
                nxt_poll = pending_polls.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
        end
        poll_valid <= nxt_valid;
        poll <= nxt_poll;
    end

    // Result receiver: stall on a rotating 16-bit pattern
    always @(negedge clk)
    begin : drive_ready
        if (stall_idx == 4'd0)
        begin
            case ($urandom_range(0, 5))
                0, 1:    stall_pattern = 16'hFFFF;
                2:       stall_pattern = 16'h0000;
                default: stall_pattern = 16'($urandom);
            endcase
        end
        result_ready <= rst_n && stall_pattern[stall_idx];
        stall_idx = stall_idx + 4'd1;
    end

    always @(posedge clk)
    begin : check_results
        bdp_pkg::result_t want;
        bit               moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                    report_mismatch("result transaction with no poll outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (result !== want)
                        report_mismatch($sformatf("result got %h expected %h", result, want));
                end
            end
            if (poll_valid && poll_ready)
            begin
                moved = 1'b1;
                expected_results.push_back(predict_panel(poll));
                poll_taken = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL button_debounce_preset_panel_top");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: first poll, switch extremes, single and joint presses,
        // held past firing, wah wrap, bounce
        push_poll(2'b00, 3'b000);
        push_poll(2'b11, 3'b000);
        push_poll(2'b01, 3'b001);
        push_poll(2'b01, 3'b001);
        push_poll(2'b01, 3'b001);
        push_poll(2'b01, 3'b001);
        push_poll(2'b10, 3'b000);
        push_poll(2'b10, 3'b111);
        push_poll(2'b10, 3'b111);
        push_poll(2'b10, 3'b111);
        push_poll(2'b00, 3'b111);
        push_poll(2'b00, 3'b000);
        push_poll(2'b11, 3'b100);
        push_poll(2'b11, 3'b100);
        push_poll(2'b11, 3'b100);
        push_poll(2'b11, 3'b000);
        push_poll(2'b01, 3'b100);
        push_poll(2'b01, 3'b100);
        push_poll(2'b01, 3'b100);
        push_poll(2'b01, 3'b000);
        push_poll(2'b10, 3'b010);
        push_poll(2'b10, 3'b000);
        push_poll(2'b10, 3'b010);
        push_poll(2'b10, 3'b010);
        push_poll(2'b10, 3'b010);
        wait_drained();

        // Hold the sender once mid-stream until every result is back
        queue_button_runs(RANDOM_POLLS_PER_SETTING / 2);
        wait_drained();
        queue_button_runs(RANDOM_POLLS_PER_SETTING / 2);

        begin : sweep_settings
            logic [3:0] settings [6];
            settings[0] = 4'd1;
            settings[1] = 4'd0;
            settings[2] = 4'd15;
            settings[3] = 4'd2;
            settings[4] = 4'($urandom_range(4, 14));
            settings[5] = bdp_pkg::POLLS_RESET;
            for (int s = 0; s < 6; s++)
            begin
                wait_drained();
                repeat (3) @(posedge clk);
                write_debounce(settings[s]);
                queue_button_runs(RANDOM_POLLS_PER_SETTING);
            end
        end

        wait_drained();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("PASS button_debounce_preset_panel_top");
        else
            $display("FAIL button_debounce_preset_panel_top");
        $finish;
    end

endmodule
